// ----- rtl/core/u16u8_pkg.sv -----
package u16u8_pkg;

    localparam int UNIT_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int SUR_W       = 10;
    localparam int BIDX_W      = 2;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Surrogate tags: top six bits of a code unit
    localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;   // D800..DBFF
    localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;   // DC00..DFFF

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [CP_W-1:0] CP_LIM_1       = 21'h000080;
    localparam logic [CP_W-1:0] CP_LIM_2       = 21'h000800;
    localparam logic [CP_W-1:0] CP_LIM_3       = 21'h010000;

    localparam logic [1:0] PFX_CONT = 2'b10;
    localparam logic [2:0] PFX_LEAD2 = 3'b110;
    localparam logic [3:0] PFX_LEAD3 = 4'b1110;
    localparam logic [4:0] PFX_LEAD4 = 5'b11110;
    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

    // One queued job: optional replacement for a flushed high surrogate,
    // optional code point, optional string terminator, in that order.
    typedef struct packed {
        logic            pre_fffd;
        logic            cp_valid;
        logic [CP_W-1:0] cp;
        logic            term;
    } t_job;

    // Index of the final byte of the code point's encoding
    function automatic logic [BIDX_W-1:0] enc_last(input logic [CP_W-1:0] cp);
        logic [BIDX_W-1:0] r;
        if (cp < CP_LIM_1) begin
            r = 2'd0;
        end else if (cp < CP_LIM_2) begin
            r = 2'd1;
        end else if (cp < CP_LIM_3) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] enc_byte(input logic [CP_W-1:0] cp,
                                                   input logic [BIDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        logic [BIDX_W-1:0] last;
        last = enc_last(cp);
        unique case (last)
            2'd0: b = cp[7:0];
            2'd1: b = (idx == 2'd0) ? {PFX_LEAD2, cp[10:6]} : {PFX_CONT, cp[5:0]};
            2'd2: begin
                unique case (idx)
                    2'd0:    b = {PFX_LEAD3, cp[15:12]};
                    2'd1:    b = {PFX_CONT, cp[11:6]};
                    default: b = {PFX_CONT, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    b = {PFX_LEAD4, cp[20:18]};
                    2'd1:    b = {PFX_CONT, cp[17:12]};
                    2'd2:    b = {PFX_CONT, cp[11:6]};
                    default: b = {PFX_CONT, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/u16u8_in_if.sv -----
interface u16u8_in_if;
    import u16u8_pkg::*;

    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              final_unit;

    modport source (output valid, code_unit, final_unit, input ready);
    modport sink   (input valid, code_unit, final_unit, output ready);
endinterface

// ----- rtl/core/u16u8_out_if.sv -----
interface u16u8_out_if;
    import u16u8_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] utf8_byte;
    logic              last_byte;

    modport source (output valid, utf8_byte, last_byte, input ready);
    modport sink   (input valid, utf8_byte, last_byte, output ready);
endinterface

// ----- rtl/core/u16u8_front.sv -----
module u16u8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    u16u8_in_if.sink         i_unit,
    input  logic             i_full,
    output logic             o_push,
    output u16u8_pkg::t_job  o_job
);
    import u16u8_pkg::*;

    logic             r_held_valid;
    logic [SUR_W-1:0] r_held_bits;
    logic             n_held_valid;
    logic [SUR_W-1:0] n_held_bits;

    logic accept;
    logic is_zero;
    logic is_high;
    logic is_low;
    logic fin;
    logic pair;
    t_job job;

    assign i_unit.ready = !i_full;
    assign accept  = i_unit.valid && i_unit.ready;
    assign is_zero = (i_unit.code_unit == '0);
    assign is_high = (i_unit.code_unit[UNIT_W-1 -: 6] == SUR_HIGH_TAG);
    assign is_low  = (i_unit.code_unit[UNIT_W-1 -: 6] == SUR_LOW_TAG);
    assign fin     = i_unit.final_unit;
    assign pair    = r_held_valid && is_low;

    always_comb begin
        job.pre_fffd = r_held_valid && !pair;
        job.cp_valid = 1'b0;
        job.cp       = CP_REPLACEMENT;
        job.term     = is_zero || fin;
        if (!is_zero) begin
            if (pair) begin
                job.cp_valid = 1'b1;
                job.cp       = CP_SUPP_BASE
                             + CP_W'({r_held_bits, i_unit.code_unit[SUR_W-1:0]});
            end else if (is_high) begin
                // held high on a final word is flushed at once
                job.cp_valid = fin;
            end else if (is_low) begin
                job.cp_valid = 1'b1;
            end else begin
                job.cp_valid = 1'b1;
                job.cp       = CP_W'(i_unit.code_unit);
            end
        end
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        if (accept) begin
            n_held_valid = !is_zero && !fin && is_high;
            n_held_bits  = (!is_zero && !fin && is_high)
                         ? i_unit.code_unit[SUR_W-1:0] : '0;
        end
    end

    assign o_push = accept && (job.pre_fffd || job.cp_valid || job.term);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

endmodule

// ----- rtl/core/u16u8_queue.sv -----
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u16u8_pkg::t_job  i_job,
    output logic             o_full,
    input  logic             i_pop,
    output u16u8_pkg::t_job  o_job,
    output logic             o_empty
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/u16u8_back.sv -----
module u16u8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  u16u8_pkg::t_job  i_job,
    output logic             o_pop,
    u16u8_out_if.source      o_byte
);
    import u16u8_pkg::*;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_CP,
        PH_TERM
    } t_phase;

    logic              r_have;
    t_job              r_job;
    t_phase            r_phase;
    logic [BIDX_W-1:0] r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic              n_have;
    t_job              n_job;
    t_phase            n_phase;
    logic [BIDX_W-1:0] n_idx;
    logic              n_out_valid;
    logic [BYTE_W-1:0] n_byte;
    logic              n_last;

    logic              load_ok;
    logic              fire;
    logic              job_done;
    logic              pop;
    logic [CP_W-1:0]   cp_sel;
    logic [BIDX_W-1:0] last_idx;
    logic [BYTE_W-1:0] cur_byte;
    t_phase            first_phase;

    assign load_ok  = !r_out_valid || o_byte.ready;
    assign fire     = r_have && load_ok;
    assign cp_sel   = (r_phase == PH_PRE) ? CP_REPLACEMENT : r_job.cp;
    assign last_idx = (r_phase == PH_TERM) ? '0 : enc_last(cp_sel);
    assign cur_byte = (r_phase == PH_TERM) ? TERM_BYTE : enc_byte(cp_sel, r_idx);

    always_comb begin
        priority if (i_job.pre_fffd) begin
            first_phase = PH_PRE;
        end else if (i_job.cp_valid) begin
            first_phase = PH_CP;
        end else begin
            first_phase = PH_TERM;
        end
    end

    always_comb begin
        n_have      = r_have;
        n_job       = r_job;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_last      = r_last;
        job_done    = 1'b0;

        // drop the shown word once taken
        if (o_byte.ready) begin
            n_out_valid = 1'b0;
        end
        if (fire) begin
            n_out_valid = 1'b1;
            n_byte      = cur_byte;
            n_last      = (r_phase == PH_TERM);
            if (r_idx != last_idx) begin
                n_idx = r_idx + 1'b1;
            end else begin
                n_idx = '0;
                unique case (r_phase)
                    PH_PRE: begin
                        priority if (r_job.cp_valid) begin
                            n_phase = PH_CP;
                        end else if (r_job.term) begin
                            n_phase = PH_TERM;
                        end else begin
                            job_done = 1'b1;
                        end
                    end
                    PH_CP: begin
                        if (r_job.term) begin
                            n_phase = PH_TERM;
                        end else begin
                            job_done = 1'b1;
                        end
                    end
                    default: job_done = 1'b1;
                endcase
            end
        end

        pop = !i_empty && (!r_have || job_done);
        if (pop) begin
            n_have  = 1'b1;
            n_job   = i_job;
            n_phase = first_phase;
            n_idx   = '0;
        end else if (job_done) begin
            n_have = 1'b0;
        end
    end

    assign o_pop            = pop;
    assign o_byte.valid     = r_out_valid;
    assign o_byte.utf8_byte = r_byte;
    assign o_byte.last_byte = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_phase     <= PH_PRE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_have      <= n_have;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_job  <= n_job;
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule

// ----- rtl/core/utf16be_to_utf8_transcoder_core.sv -----
// UTF-16 to UTF-8 transcoder. Each input word is one 16-bit code unit; each
// output word is one UTF-8 byte. A unit is taken whenever the job queue has
// room, and bytes leave at one per cycle from a registered output while the
// sink is ready, so the sustained rate is set by the output byte count of
// each unit: one byte for ASCII, two or three for other BMP characters, four
// for a surrogate pair (spread over its two units), and up to seven for a
// unit that ends the string after a held high surrogate: three bytes of
// replacement for the held unit, up to three for the unit itself, then the
// terminator. A high surrogate is held and gives no byte until the
// next unit; an unpaired surrogate becomes U+FFFD (EF BF BD). A zero unit or
// a unit with final_unit set closes the string with a single zero byte marked
// last_byte, after flushing any held surrogate, and clears the held state.
module utf16be_to_utf8_transcoder_core #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u16u8_in_if.sink      i_unit,
    u16u8_out_if.source   o_byte
);
    import u16u8_pkg::*;

    // front to queue
    logic push;
    t_job push_job;
    logic full;

    // queue to back
    logic pop;
    t_job head_job;
    logic empty;

    // Front: classify each unit, track the held high surrogate, and hand a
    // job (replacement, code point, terminator) to the queue.
    u16u8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_unit  (i_unit),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Short queue: lets the front keep taking units while the back drains
    // multi-byte jobs.
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    // Back: walk each job byte by byte into the output register; advance to
    // the next job, if one is queued, in the same cycle as its last byte is loaded.
    u16u8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule
